>>> design/owf_pkg.sv
// ----------------------------------------------------------------------------
// owf_pkg
// Shared types and constants for the overlapping window framer.
// ----------------------------------------------------------------------------
package owf_pkg;

  // Sample and configuration widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned CfgIdxW   = 2;

  // Default ring depth (largest frame)
  localparam int unsigned WindowMaxDef = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegWindowSize = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegHopSize    = CfgIdxW'(1);

  // Configuration reset values
  localparam logic [CfgDataW-1:0] WindowSizeRst = CfgDataW'(64);
  localparam logic [CfgDataW-1:0] HopSizeRst    = CfgDataW'(32);

  // Control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } owf_state_e;

endpackage : owf_pkg

>>> design/overlapping_window_framer_unit.sv
// ----------------------------------------------------------------------------
// overlapping_window_framer_unit
// Cuts a sample stream into overlapping frames held in a sample ring RAM.
// ----------------------------------------------------------------------------
// Input: a sample that completes no frame leaves the input ready for the next;
// one that completes a frame starts a readout of window_size ring entries (one
// RAM read port, one read per cycle while the output buffer has room), during
// which input transfers stall. Output: the first frame sample passes the read
// address, RAM read and output registers; then one sample per cycle unless stalled.
// Reset: control, counters and configuration clear at once; ring RAM contents
// stay undefined and need no clearing pass, since only written entries are read.
module overlapping_window_framer_unit #(
  parameter int unsigned WindowMax = owf_pkg::WindowMaxDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [owf_pkg::SampleW-1:0]  sample_i,
  // frame output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [owf_pkg::SampleW-1:0]  frame_sample_o,
  output logic                                frame_last_o,
  // configuration write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [owf_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [owf_pkg::CfgDataW-1:0]        cfg_data_i
);

  // Ring address width and count width (count can hold WindowMax itself)
  localparam int unsigned PW = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int unsigned HW = $clog2(WindowMax + 1);
  localparam int unsigned SW = HW + 1;
  localparam int unsigned DW = owf_pkg::SampleW;
  localparam int unsigned CW = owf_pkg::CfgDataW;

  // --------------------------------------------------------------------------
  // Configuration registers: raw values, clamped where used
  // --------------------------------------------------------------------------
  logic [CW-1:0] win_raw_q, win_raw_d;
  logic [CW-1:0] hop_raw_q, hop_raw_d;
  logic          cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    win_raw_d = win_raw_q;
    hop_raw_d = hop_raw_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        owf_pkg::RegWindowSize: win_raw_d = cfg_data_i;
        owf_pkg::RegHopSize:    hop_raw_d = cfg_data_i;
        default: ;  // unknown index: ignore the transfer
      endcase
    end
  end

  // Zero acts as one, anything above the ring depth acts as the ring depth
  logic [HW-1:0] win_len;
  logic [HW-1:0] hop_len;

  always_comb begin
    if (win_raw_q == '0) begin
      win_len = HW'(1);
    end else if (win_raw_q > CW'(WindowMax)) begin
      win_len = HW'(WindowMax);
    end else begin
      win_len = win_raw_q[HW-1:0];
    end
    if (hop_raw_q == '0) begin
      hop_len = HW'(1);
    end else if (hop_raw_q > CW'(WindowMax)) begin
      hop_len = HW'(WindowMax);
    end else begin
      hop_len = hop_raw_q[HW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Ring bookkeeping
  // --------------------------------------------------------------------------
  owf_pkg::owf_state_e state_q, state_d;

  logic [PW-1:0] wp_q, wp_d;         // next ring slot to write
  logic [HW-1:0] held_q, held_d;     // samples currently held
  logic [PW-1:0] skip_q, skip_d;     // incoming samples still to drop
  logic [PW-1:0] rd_addr_q, rd_addr_d;
  logic [HW-1:0] rem_q, rem_d;       // reads left in the current frame

  logic          in_xfer;
  logic          skipping;
  logic          wr_en;
  logic          trigger;
  logic          issue;
  logic          can_issue;
  logic          read_done;
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] rd_addr_inc;
  logic [HW-1:0] held_inc;
  logic [SW-1:0] wp_ext;
  logic [SW-1:0] held_ext;
  logic [PW-1:0] start_addr;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign skipping = (skip_q != '0);
  assign wr_en    = in_xfer && !skipping;

  assign wp_inc      = (wp_q == PW'(WindowMax - 1)) ? '0 : wp_q + PW'(1);
  assign rd_addr_inc = (rd_addr_q == PW'(WindowMax - 1)) ? '0 : rd_addr_q + PW'(1);
  assign held_inc    = (held_q < HW'(WindowMax)) ? held_q + HW'(1) : held_q;
  assign trigger     = wr_en && (held_inc >= win_len);

  // Oldest held sample, counted back from the slot after the new one
  assign wp_ext   = SW'(wp_inc);
  assign held_ext = SW'(held_inc);

  always_comb begin
    if (wp_ext >= held_ext) begin
      start_addr = PW'(wp_ext - held_ext);
    end else begin
      start_addr = PW'(wp_ext + SW'(WindowMax) - held_ext);
    end
  end

  // Next state
  assign read_done = issue && (rem_q == HW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      owf_pkg::ST_IDLE: if (trigger) state_d = owf_pkg::ST_READ;
      owf_pkg::ST_READ: if (read_done) state_d = owf_pkg::ST_IDLE;
      default:          state_d = owf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: stall input during readout, issue reads when room
  always_comb begin
    in_stall_o = 1'b0;
    issue      = 1'b0;
    unique case (state_q)
      owf_pkg::ST_IDLE: in_stall_o = 1'b0;
      owf_pkg::ST_READ: begin
        in_stall_o = 1'b1;
        issue      = can_issue;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // Counter updates
  always_comb begin
    wp_d      = wp_q;
    held_d    = held_q;
    skip_d    = skip_q;
    rd_addr_d = rd_addr_q;
    rem_d     = rem_q;

    if (in_xfer) begin
      if (skipping) begin
        // drop the sample that falls between frames
        skip_d = skip_q - PW'(1);
      end else begin
        wp_d   = wp_inc;
        held_d = held_inc;
        if (trigger) begin
          rd_addr_d = start_addr;
          rem_d     = win_len;
          if (hop_len <= held_inc) begin
            held_d = held_inc - hop_len;
          end else begin
            held_d = '0;
            skip_d = PW'(hop_len - held_inc);
          end
        end
      end
    end

    if (issue) begin
      rd_addr_d = rd_addr_inc;
      rem_d     = rem_q - HW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Sample ring RAM
  // --------------------------------------------------------------------------
  logic [DW-1:0] ram_rdata;

  owf_ram #(
    .DataW (DW),
    .Depth (WindowMax)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .re_i    (issue),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Output register plus one skid entry; a read is issued only when the
  // buffer can still take its data once the RAM read register returns it.
  // --------------------------------------------------------------------------
  logic          rd_pend_q, rd_pend_d;
  logic          rd_last_q, rd_last_d;
  logic          out_vld_q, out_vld_d;
  logic [DW-1:0] out_data_q, out_data_d;
  logic          out_last_q, out_last_d;
  logic          skid_vld_q, skid_vld_d;
  logic [DW-1:0] skid_data_q, skid_data_d;
  logic          skid_last_q, skid_last_d;
  logic          out_pop;
  logic          out_take;
  logic [1:0]    occ;

  assign out_pop   = out_vld_q && !out_stall_i;
  assign out_take  = !out_vld_q || !out_stall_i;
  assign occ       = 2'(out_vld_q) + 2'(skid_vld_q) + 2'(rd_pend_q);
  assign can_issue = (occ - 2'(out_pop)) < 2'd2;

  assign rd_pend_d = issue;
  assign rd_last_d = read_done;

  always_comb begin
    out_vld_d   = out_vld_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    skid_vld_d  = skid_vld_q;
    skid_data_d = skid_data_q;
    skid_last_d = skid_last_q;

    if (out_take) begin
      if (skid_vld_q) begin
        // advance skid into output, refill skid from RAM
        out_vld_d   = 1'b1;
        out_data_d  = skid_data_q;
        out_last_d  = skid_last_q;
        skid_vld_d  = rd_pend_q;
        skid_data_d = ram_rdata;
        skid_last_d = rd_last_q;
      end else if (rd_pend_q) begin
        out_vld_d  = 1'b1;
        out_data_d = ram_rdata;
        out_last_d = rd_last_q;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (rd_pend_q) begin
      // output held by stall: park read data
      skid_vld_d  = 1'b1;
      skid_data_d = ram_rdata;
      skid_last_d = rd_last_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign frame_sample_o = out_data_q;
  assign frame_last_o   = out_last_q;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_raw_q  <= owf_pkg::WindowSizeRst;
      hop_raw_q  <= owf_pkg::HopSizeRst;
      state_q    <= owf_pkg::ST_IDLE;
      wp_q       <= '0;
      held_q     <= '0;
      skip_q     <= '0;
      rd_addr_q  <= '0;
      rem_q      <= '0;
      rd_pend_q  <= 1'b0;
      rd_last_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      win_raw_q  <= win_raw_d;
      hop_raw_q  <= hop_raw_d;
      state_q    <= state_d;
      wp_q       <= wp_d;
      held_q     <= held_d;
      skip_q     <= skip_d;
      rd_addr_q  <= rd_addr_d;
      rem_q      <= rem_d;
      rd_pend_q  <= rd_pend_d;
      rd_last_q  <= rd_last_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
    skid_data_q <= skid_data_d;
    skid_last_q <= skid_last_d;
  end

`ifndef ASSERT_OFF
  // Skid entry only fills behind a stalled output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while output register empty");

  // Read credit: no read in flight while the skid entry is occupied
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !rd_pend_q)
    else $error("read data in flight with full output buffer");

  // Ring writes and readout never overlap
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && issue))
    else $error("ring write during frame readout");

  // Held count stays within the ring
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HW'(WindowMax))
    else $error("held count exceeds ring depth");

  // A frame completing sends its last read when the sequencer returns to idle
  a_last_on_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == owf_pkg::ST_READ && state_d == owf_pkg::ST_IDLE) |=> rd_last_q)
    else $error("readout ended without a last sample");
`endif

endmodule : overlapping_window_framer_unit

>>> design/owf_ram.sv
// ----------------------------------------------------------------------------
// owf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module owf_ram #(
  parameter int unsigned DataW = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : owf_ram
